>>> hdl/fidf_pkg.sv
package fidf_pkg;

    localparam int unsigned EntryBytes = 20;
    localparam int unsigned ChunksPerSegment = 4;

    localparam logic [31:0] SigSdp  = {8'h53, 8'h44, 8'h50, 8'h20};
    localparam logic [31:0] SigFram = {8'h46, 8'h52, 8'h41, 8'h4d};
    localparam logic [31:0] SigFlag = {8'h46, 8'h4c, 8'h41, 8'h47};
    localparam logic [31:0] SigIndx = {8'h49, 8'h4e, 8'h44, 8'h58};

    typedef enum logic [2:0] {
        PH_SEG,
        PH_FMTP,
        PH_CHDR,
        PH_SKIP,
        PH_FLAG,
        PH_ENTRY
    } t_phase;

    typedef struct packed {
        logic signed [63:0] frame_timestamp;
        logic signed [63:0] frame_offset;
        logic signed [63:0] frame_size;
        logic [31:0]        frame_flags;
        logic [31:0]        segment_flags;
        logic [31:0]        clock_rate;
        logic [31:0]        codec_code;
        logic [31:0]        chunk_group_number;
        logic [31:0]        segment_number;
    } t_result;

    // Quotient digit of v / 20 for v < 320, by reciprocal multiply (205 / 4096).
    function automatic logic [3:0] fidf_div20_digit(input logic [8:0] v);
        logic [16:0] prod;
        prod = {8'd0, v} * 17'd205;
        return prod[15:12];
    endfunction

endpackage

>>> hdl/fidf_front.sv
module fidf_front
    import fidf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_push,
    output t_result     o_item
);

    t_phase      r_phase, n_phase;
    logic [63:0] r_pos, n_pos;
    logic [63:0] r_shift, n_shift;
    logic [4:0]  r_k, n_k;
    logic [63:0] r_rem, n_rem;
    logic [2:0]  r_chunk, n_chunk;
    logic [31:0] r_ent, n_ent;
    logic [31:0] r_id, n_id;
    logic [31:0] r_codec, n_codec;
    logic [31:0] r_clock, n_clock;
    logic [31:0] r_sflags, n_sflags;
    logic [63:0] r_start, n_start;
    logic [63:0] r_end, n_end;
    logic [63:0] r_ptime, n_ptime;
    logic [63:0] r_poff, n_poff;
    logic [31:0] r_pflags, n_pflags;
    logic        r_pvalid, n_pvalid;
    logic [31:0] r_group, n_group;
    logic [63:0] r_ntime, n_ntime;
    logic [4:0]  r_divr, n_divr;
    logic [31:0] r_divq, n_divq;

    always_comb begin
        t_phase      c_phase;
        logic [63:0] c_pos, c_rem, c_start, c_poff;
        logic [31:0] c_low, c_ent, c_group;
        logic [4:0]  c_k, c_dr, c_r1, c_r2;
        logic [2:0]  c_chunk_inc;
        logic [8:0]  c_v1, c_v2;
        logic [3:0]  c_q1, c_q2;
        logic [31:0] c_dq;
        logic        c_done;

        c_phase = i_first_byte ? PH_SEG : r_phase;
        c_pos   = i_first_byte ? 64'd0 : r_pos;
        c_k     = i_first_byte ? 5'd0 : r_k;
        c_rem   = i_first_byte ? 64'd0 : r_rem;
        c_start = i_first_byte ? 64'd0 : r_start;
        c_poff  = i_first_byte ? 64'd0 : r_poff;
        c_ent   = i_first_byte ? 32'd0 : r_ent;
        c_group = i_first_byte ? 32'd0 : r_group;

        n_phase  = c_phase;
        n_pos    = c_pos + 64'd1;
        n_shift  = {(i_first_byte ? 56'd0 : r_shift[55:0]), i_data_byte};
        c_low    = n_shift[31:0];
        n_k      = c_k;
        n_rem    = c_rem;
        n_chunk  = i_first_byte ? 3'd0 : r_chunk;
        n_ent    = c_ent;
        n_id     = i_first_byte ? 32'd0 : r_id;
        n_codec  = i_first_byte ? 32'd0 : r_codec;
        n_clock  = i_first_byte ? 32'd0 : r_clock;
        n_sflags = i_first_byte ? 32'd0 : r_sflags;
        n_start  = c_start;
        n_end    = i_first_byte ? 64'd0 : r_end;
        n_ptime  = i_first_byte ? 64'd0 : r_ptime;
        n_poff   = c_poff;
        n_pflags = i_first_byte ? 32'd0 : r_pflags;
        n_pvalid = i_first_byte ? 1'b0 : r_pvalid;
        n_group  = c_group;
        n_ntime  = i_first_byte ? 64'd0 : r_ntime;
        c_done   = 1'b0;

        // Payload size / 20 is formed digit by digit while the size bytes arrive.
        c_dr  = (c_k == 5'd0) ? 5'd0 : r_divr;
        c_dq  = (c_k == 5'd0) ? 32'd0 : r_divq;
        c_v1  = {c_dr, i_data_byte[7:4]};
        c_q1  = fidf_div20_digit(c_v1);
        c_r1  = 5'(c_v1 - 9'(c_q1) * 9'd20);
        c_v2  = {c_r1, i_data_byte[3:0]};
        c_q2  = fidf_div20_digit(c_v2);
        c_r2  = 5'(c_v2 - 9'(c_q2) * 9'd20);
        n_divr = i_first_byte ? 5'd0 : r_divr;
        n_divq = i_first_byte ? 32'd0 : r_divq;
        if (c_phase == PH_CHDR && c_k < 5'd8) begin
            n_divr = c_r2;
            n_divq = {c_dq[23:0], c_q1, c_q2};
        end

        o_push = 1'b0;
        o_item = '0;
        o_item.segment_flags      = n_sflags;
        o_item.clock_rate         = n_clock;
        o_item.codec_code         = n_codec;
        o_item.segment_number     = n_id;
        o_item.chunk_group_number = c_group;

        case (c_phase)
            PH_SEG: begin
                if (c_k == 5'd15) n_id = c_low;
                else if (c_k == 5'd19) n_codec = c_low;
                else if (c_k == 5'd23) n_clock = c_low;
                if (c_k >= 5'd27) begin
                    n_rem    = {32'd0, c_low};
                    n_sflags = 32'd0;
                    n_start  = 64'd0;
                    n_end    = 64'd0;
                    n_chunk  = 3'd0;
                    n_k      = 5'd0;
                    n_phase  = (c_low != 32'd0) ? PH_FMTP : PH_CHDR;
                end else begin
                    n_k = c_k + 5'd1;
                end
            end
            PH_FMTP: begin
                n_rem = c_rem - 64'd1;
                if (n_rem == 64'd0) begin
                    n_k     = 5'd0;
                    n_phase = PH_CHDR;
                end
            end
            PH_CHDR: begin
                if (c_k == 5'd7) n_rem = n_shift;
                if (c_k < 5'd11) begin
                    n_k = c_k + 5'd1;
                end else begin
                    n_k = 5'd0;
                    if (c_low == SigSdp) begin
                        if (c_rem != 64'd0) n_phase = PH_SKIP;
                        else c_done = 1'b1;
                    end else if (c_low == SigFram) begin
                        n_start = c_pos + 64'd1;
                        n_end   = c_pos + 64'd1 + c_rem;
                        if (c_rem != 64'd0) n_phase = PH_SKIP;
                        else c_done = 1'b1;
                    end else if (c_low == SigFlag) begin
                        n_phase = PH_FLAG;
                    end else if (c_low == SigIndx) begin
                        n_ent    = r_divq;
                        n_pvalid = 1'b0;
                        if (r_divq == 32'd0) begin
                            n_group = c_group + 32'd1;
                            c_done  = 1'b1;
                        end else begin
                            n_phase = PH_ENTRY;
                        end
                    end else begin
                        c_done = 1'b1;
                    end
                end
            end
            PH_SKIP: begin
                n_rem = c_rem - 64'd1;
                if (n_rem == 64'd0) c_done = 1'b1;
            end
            PH_FLAG: begin
                if (c_k >= 5'd3) begin
                    n_sflags = c_low;
                    c_done   = 1'b1;
                end else begin
                    n_k = c_k + 5'd1;
                end
            end
            PH_ENTRY: begin
                if (c_k == 5'd7) begin
                    n_ntime = n_shift;
                end else if (c_k == 5'd15) begin
                    if (r_pvalid && !i_first_byte) begin
                        o_push = 1'b1;
                        o_item.frame_timestamp = r_ptime;
                        o_item.frame_offset    = c_poff;
                        o_item.frame_size      = (c_start + n_shift) - c_poff;
                        o_item.frame_flags     = r_pflags;
                    end
                    n_pvalid = 1'b0;
                    n_ptime  = i_first_byte ? 64'd0 : r_ntime;
                    n_poff   = n_shift + c_start;
                end
                if (c_k >= 5'(EntryBytes - 1)) begin
                    n_pflags = c_low;
                    n_pvalid = 1'b1;
                    n_k      = 5'd0;
                    n_ent    = c_ent - 32'd1;
                    if (n_ent == 32'd0) begin
                        o_push = 1'b1;
                        o_item.frame_timestamp = n_ptime;
                        o_item.frame_offset    = n_poff;
                        o_item.frame_size      = n_end - n_poff;
                        o_item.frame_flags     = c_low;
                        n_pvalid = 1'b0;
                        n_group  = c_group + 32'd1;
                        c_done   = 1'b1;
                    end
                end else begin
                    n_k = c_k + 5'd1;
                end
            end
            default: begin
                n_phase = PH_SEG;
                n_k     = 5'd0;
            end
        endcase

        c_chunk_inc = n_chunk + 3'd1;
        if (c_done) begin
            n_k = 5'd0;
            if (c_chunk_inc >= 3'(ChunksPerSegment)) begin
                n_chunk = 3'd0;
                n_phase = PH_SEG;
            end else begin
                n_chunk = c_chunk_inc;
                n_phase = PH_CHDR;
            end
        end

        o_push = o_push & i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEG;
            r_pos    <= '0;
            r_shift  <= '0;
            r_k      <= '0;
            r_rem    <= '0;
            r_chunk  <= '0;
            r_ent    <= '0;
            r_id     <= '0;
            r_codec  <= '0;
            r_clock  <= '0;
            r_sflags <= '0;
            r_start  <= '0;
            r_end    <= '0;
            r_ptime  <= '0;
            r_poff   <= '0;
            r_pflags <= '0;
            r_pvalid <= 1'b0;
            r_group  <= '0;
            r_ntime  <= '0;
            r_divr   <= '0;
            r_divq   <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_shift  <= n_shift;
            r_k      <= n_k;
            r_rem    <= n_rem;
            r_chunk  <= n_chunk;
            r_ent    <= n_ent;
            r_id     <= n_id;
            r_codec  <= n_codec;
            r_clock  <= n_clock;
            r_sflags <= n_sflags;
            r_start  <= n_start;
            r_end    <= n_end;
            r_ptime  <= n_ptime;
            r_poff   <= n_poff;
            r_pflags <= n_pflags;
            r_pvalid <= n_pvalid;
            r_group  <= n_group;
            r_ntime  <= n_ntime;
            r_divr   <= n_divr;
            r_divq   <= n_divq;
        end
    end

endmodule

>>> hdl/fidf_queue.sv
module fidf_queue
    import fidf_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_item,
    output logic    o_has_room,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_item
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PtrW-1:0]  r_wp, n_wp;
    logic [PtrW-1:0]  r_rp, n_rp;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             c_do_pop;

    assign o_valid    = (r_cnt != '0);
    assign o_has_room = (r_cnt < CntW'(DEPTH));
    assign o_item     = r_mem[r_rp];
    assign c_do_pop   = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PtrW'(DEPTH - 1)) ? '0 : r_wp + PtrW'(1);
        end
        if (c_do_pop) begin
            n_rp = (r_rp == PtrW'(DEPTH - 1)) ? '0 : r_rp + PtrW'(1);
        end
        if (i_push && !c_do_pop) n_cnt = r_cnt + CntW'(1);
        else if (!i_push && c_do_pop) n_cnt = r_cnt - CntW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_has_room)
        else $error("push into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(DEPTH))
        else $error("queue count out of range");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_valid) |=> o_valid)
        else $error("pushed transaction not visible");

endmodule

>>> hdl/frame_index_deframer_unit.sv
// Byte-stream parser for recorded media responses. One byte is taken per clock;
// o_ready stays high while the result queue (QUEUE_DEPTH entries) has room, so the
// sustained rate is one byte per cycle as long as results are drained. An index
// entry is pushed when the next entry's offset or the last entry's flags complete;
// pushed into an empty queue, it shows in the next cycle via the queue's registers.
// The index entry count is divided out digit-serially as the chunk size bytes arrive.
module frame_index_deframer_unit
    import fidf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_frame_timestamp,
    output logic signed [63:0] o_frame_offset,
    output logic signed [63:0] o_frame_size,
    output logic [31:0]        o_frame_flags,
    output logic [31:0]        o_segment_flags,
    output logic [31:0]        o_clock_rate,
    output logic [31:0]        o_codec_code,
    output logic [31:0]        o_chunk_group_number,
    output logic [31:0]        o_segment_number
);

    logic    c_fire;
    logic    c_push;
    t_result c_item;
    t_result c_head;

    assign c_fire = i_valid && o_ready;

    fidf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (c_fire),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .o_push       (c_push),
        .o_item       (c_item)
    );

    fidf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (c_push),
        .i_item     (c_item),
        .o_has_room (o_ready),
        .o_valid    (o_valid),
        .i_pop      (i_ready),
        .o_item     (c_head)
    );

    assign o_frame_timestamp    = c_head.frame_timestamp;
    assign o_frame_offset       = c_head.frame_offset;
    assign o_frame_size         = c_head.frame_size;
    assign o_frame_flags        = c_head.frame_flags;
    assign o_segment_flags      = c_head.segment_flags;
    assign o_clock_rate         = c_head.clock_rate;
    assign o_codec_code         = c_head.codec_code;
    assign o_chunk_group_number = c_head.chunk_group_number;
    assign o_segment_number     = c_head.segment_number;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import fidf_pkg::*;

    class entry_scoreboard;
        t_phase      phase;
        logic [63:0] position;
        logic [63:0] shift_word;
        logic [63:0] remaining;
        logic [4:0]  field_count;
        logic [2:0]  chunk_index;
        logic [31:0] signature;
        logic [31:0] entries_left;
        logic [31:0] seg_words [4];
        logic [63:0] area [2];
        logic [63:0] held [3];
        bit          held_valid;
        logic [31:0] group_count;
        logic [63:0] next_stamp;
        t_result     expected_q [$];
        int          errors;
        int          matched;

        function new();
            errors = 0;
            matched = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_SEG;
            position = '0;
            shift_word = '0;
            remaining = '0;
            field_count = '0;
            chunk_index = '0;
            signature = '0;
            entries_left = '0;
            foreach (seg_words[i]) seg_words[i] = '0;
            area[0] = '0;
            area[1] = '0;
            foreach (held[i]) held[i] = '0;
            held_valid = 0;
            group_count = '0;
            next_stamp = '0;
        endfunction

        function void chunk_finished();
            chunk_index = chunk_index + 3'd1;
            field_count = '0;
            if (chunk_index >= ChunksPerSegment) begin
                chunk_index = '0;
                phase = PH_SEG;
            end else begin
                phase = PH_CHDR;
            end
        endfunction

        function void push_entry(logic [63:0] size);
            t_result r;
            r.frame_timestamp    = held[0];
            r.frame_offset       = held[1];
            r.frame_size         = size;
            r.frame_flags        = held[2][31:0];
            r.segment_flags      = seg_words[3];
            r.clock_rate         = seg_words[2];
            r.codec_code         = seg_words[1];
            r.chunk_group_number = group_count;
            r.segment_number     = seg_words[0];
            expected_q.push_back(r);
        endfunction

        // Called once per accepted input transaction.
        function void note_byte(logic [7:0] data, logic first);
            logic [63:0] here;
            logic [31:0] low;
            int          k;
            if (first) clear();
            here = position;
            position = here + 64'd1;
            shift_word = {shift_word[55:0], data};
            low = shift_word[31:0];
            k = field_count;
            case (phase)
                PH_SEG: begin
                    if (k == 15) seg_words[0] = low;
                    else if (k == 19) seg_words[1] = low;
                    else if (k == 23) seg_words[2] = low;
                    if (k >= 27) begin
                        remaining = {32'd0, low};
                        seg_words[3] = '0;
                        area[0] = '0;
                        area[1] = '0;
                        chunk_index = '0;
                        field_count = '0;
                        phase = (remaining != 0) ? PH_FMTP : PH_CHDR;
                    end else begin
                        field_count = 5'(k + 1);
                    end
                end
                PH_FMTP: begin
                    remaining = remaining - 64'd1;
                    if (remaining == 0) begin
                        field_count = '0;
                        phase = PH_CHDR;
                    end
                end
                PH_CHDR: begin
                    if (k == 7) remaining = shift_word;
                    if (k < 11) begin
                        field_count = 5'(k + 1);
                    end else begin
                        signature = low;
                        field_count = '0;
                        if (signature == SigSdp) begin
                            if (remaining != 0) phase = PH_SKIP;
                            else chunk_finished();
                        end else if (signature == SigFram) begin
                            area[0] = here + 64'd1;
                            area[1] = here + 64'd1 + remaining;
                            if (remaining != 0) phase = PH_SKIP;
                            else chunk_finished();
                        end else if (signature == SigFlag) begin
                            phase = PH_FLAG;
                        end else if (signature == SigIndx) begin
                            entries_left = 32'(remaining / EntryBytes);
                            held_valid = 0;
                            if (entries_left == 0) begin
                                group_count = group_count + 32'd1;
                                chunk_finished();
                            end else begin
                                phase = PH_ENTRY;
                            end
                        end else begin
                            chunk_finished();
                        end
                    end
                end
                PH_SKIP: begin
                    remaining = remaining - 64'd1;
                    if (remaining == 0) chunk_finished();
                end
                PH_FLAG: begin
                    if (k >= 3) begin
                        seg_words[3] = low;
                        chunk_finished();
                    end else begin
                        field_count = 5'(k + 1);
                    end
                end
                PH_ENTRY: begin
                    if (k == 7) begin
                        next_stamp = shift_word;
                    end else if (k == 15) begin
                        if (held_valid) push_entry((area[0] + shift_word) - held[1]);
                        held_valid = 0;
                        held[0] = next_stamp;
                        held[1] = shift_word + area[0];
                    end
                    if (k >= EntryBytes - 1) begin
                        held[2] = {32'd0, low};
                        held_valid = 1;
                        field_count = '0;
                        entries_left = entries_left - 32'd1;
                        if (entries_left == 0) begin
                            push_entry(area[1] - held[1]);
                            held_valid = 0;
                            group_count = group_count + 32'd1;
                            chunk_finished();
                        end
                    end else begin
                        field_count = 5'(k + 1);
                    end
                end
                default: begin
                    phase = PH_SEG;
                    field_count = '0;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name,
                         want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            int      before_errors;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
                errors++;
                return;
            end
            before_errors = errors;
            want = expected_q.pop_front();
            compare_field("frame_timestamp", want.frame_timestamp, got.frame_timestamp);
            compare_field("frame_offset", want.frame_offset, got.frame_offset);
            compare_field("frame_size", want.frame_size, got.frame_size);
            compare_field("frame_flags", want.frame_flags, got.frame_flags);
            compare_field("segment_flags", want.segment_flags, got.segment_flags);
            compare_field("clock_rate", want.clock_rate, got.clock_rate);
            compare_field("codec_code", want.codec_code, got.codec_code);
            compare_field("chunk_group_number", want.chunk_group_number,
                          got.chunk_group_number);
            compare_field("segment_number", want.segment_number, got.segment_number);
            if (errors == before_errors) matched++;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_data_byte;
    logic               i_first_byte;
    logic               o_valid;
    logic               i_ready;
    logic signed [63:0] o_frame_timestamp;
    logic signed [63:0] o_frame_offset;
    logic signed [63:0] o_frame_size;
    logic [31:0]        o_frame_flags;
    logic [31:0]        o_segment_flags;
    logic [31:0]        o_clock_rate;
    logic [31:0]        o_codec_code;
    logic [31:0]        o_chunk_group_number;
    logic [31:0]        o_segment_number;

    frame_index_deframer_unit i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_data_byte          (i_data_byte),
        .i_first_byte         (i_first_byte),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_frame_timestamp    (o_frame_timestamp),
        .o_frame_offset       (o_frame_offset),
        .o_frame_size         (o_frame_size),
        .o_frame_flags        (o_frame_flags),
        .o_segment_flags      (o_segment_flags),
        .o_clock_rate         (o_clock_rate),
        .o_codec_code         (o_codec_code),
        .o_chunk_group_number (o_chunk_group_number),
        .o_segment_number     (o_segment_number)
    );

    entry_scoreboard sb = new();

    int          send_idle = 13;
    int          recv_idle = 46;
    int          bytes_sent = 0;
    int          responses = 0;
    bit          start_flag = 0;
    logic [8:0]  stream_q [$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_ready <= 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Outputs are checked mid-cycle, where they are stable up to the next edge.
    initial begin
        t_result got;
        forever begin
            @(negedge i_clk);
            #1;
            if (i_rst_n && o_valid && i_ready) begin
                got.frame_timestamp    = o_frame_timestamp;
                got.frame_offset       = o_frame_offset;
                got.frame_size         = o_frame_size;
                got.frame_flags        = o_frame_flags;
                got.segment_flags      = o_segment_flags;
                got.clock_rate         = o_clock_rate;
                got.codec_code         = o_codec_code;
                got.chunk_group_number = o_chunk_group_number;
                got.segment_number     = o_segment_number;
                sb.check_result(got);
            end
        end
    end

    task automatic send_byte(logic [7:0] data, logic first);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_data_byte <= data;
        i_first_byte <= first;
        do @(negedge i_clk); while (!o_ready);
        sb.note_byte(data, first);
        bytes_sent++;
        @(posedge i_clk);
    endtask

    task automatic put_byte(logic [7:0] data);
        stream_q.push_back({start_flag, data});
        start_flag = 0;
    endtask

    task automatic put_be(logic [63:0] value, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) put_byte(value[i*8 +: 8]);
    endtask

    task automatic put_random(int count);
        for (int i = 0; i < count; i++) put_byte(8'($urandom_range(255)));
    endtask

    task automatic flush_stream();
        while (stream_q.size() > 0) begin
            logic [8:0] b;
            b = stream_q.pop_front();
            send_byte(b[7:0], b[8]);
        end
    endtask

    task automatic begin_response();
        start_flag = 1;
        responses++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic put_segment(logic [31:0] id, logic [31:0] codec, logic [31:0] rate,
                               int fmtp_len);
        put_random(12);
        put_be({32'd0, id}, 4);
        put_be({32'd0, codec}, 4);
        put_be({32'd0, rate}, 4);
        put_be(64'(fmtp_len), 4);
        put_random(fmtp_len);
    endtask

    task automatic put_chunk(logic [63:0] size, logic [31:0] sig);
        put_be(size, 8);
        put_be({32'd0, sig}, 4);
    endtask

    task automatic put_entry(logic [63:0] stamp, logic [63:0] offset, logic [31:0] flags);
        put_be(stamp, 8);
        put_be(offset, 8);
        put_be({32'd0, flags}, 4);
    endtask

    // Index chunk with count entries; extra adds a size remainder that is not sent.
    task automatic put_index(int count, int extra);
        logic [63:0] offset;
        offset = 64'($urandom_range(15));
        put_chunk(64'(count * 20 + extra), SigIndx);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) offset = rand64();
            else offset = offset + 64'($urandom_range(300));
            put_entry(rand64(), offset, $urandom());
        end
    endtask

    task automatic put_random_chunk();
        case ($urandom_range(5))
            0: begin
                int n;
                n = $urandom_range(6);
                put_chunk(64'(n), SigSdp);
                put_random(n);
            end
            1, 2: begin
                int n;
                n = $urandom_range(8);
                put_chunk(64'(n), SigFram);
                put_random(n);
            end
            3: begin
                put_chunk(rand64(), SigFlag);
                put_be(64'($urandom()), 4);
            end
            4: begin
                put_index($urandom_range(1, 4),
                          ($urandom_range(3) == 0) ? $urandom_range(19) : 0);
            end
            default: begin
                if ($urandom_range(4) == 0) put_index(0, $urandom_range(19));
                else put_chunk(64'($urandom_range(40)), $urandom());
            end
        endcase
    endtask

    task automatic random_response();
        int cut;
        begin_response();
        if ($urandom_range(19) == 0) begin
            // Garbage that may lock the parser into a long skip until the next restart.
            put_random($urandom_range(1, 60));
        end else begin
            for (int s = $urandom_range(1, 3); s > 0; s--) begin
                put_segment($urandom(), $urandom(), $urandom(), $urandom_range(3));
                // Index chunks dominate so that entries keep flowing.
                for (int c = 0; c < 4; c++) begin
                    if ($urandom_range(2) == 0) put_index($urandom_range(1, 4), 0);
                    else put_random_chunk();
                end
            end
            if ($urandom_range(9) == 0) begin
                cut = $urandom_range(1, stream_q.size());
                while (stream_q.size() > cut) void'(stream_q.pop_back());
            end
        end
        flush_stream();
    endtask

    initial begin
        int limit;
        i_rst_n <= 0;
        i_valid <= 0;
        i_data_byte <= '0;
        i_first_byte <= 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: full segment with extreme header words and entry fields.
        begin_response();
        put_segment(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 3);
        put_chunk(64'd2, SigSdp);
        put_random(2);
        put_chunk(64'd5, SigFram);
        put_random(5);
        put_chunk(64'd4, SigFlag);
        put_be(64'h0000_0000_FFFF_FFFF, 4);
        put_chunk(64'd60, SigIndx);
        put_entry(64'h8000_0000_0000_0000, 64'h0, 32'h0);
        put_entry(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        put_entry(64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A);
        // Empty fmtp, unknown signature, empty index, index size with a remainder.
        put_segment(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        put_chunk(64'd9, 32'h5858_5858);
        put_chunk(64'd0, SigIndx);
        put_index(2, 7);
        put_chunk(64'd0, SigSdp);
        flush_stream();

        // No frame area chunk; then a huge index size cut off by a restart mid-entry.
        begin_response();
        put_segment(32'h1234_5678, 32'h1, 32'd90000, 1);
        put_chunk(64'd4, SigFlag);
        put_be(64'h0000_0000_0000_0001, 4);
        put_index(1, 0);
        put_chunk(64'd0, SigFram);
        put_chunk(64'hFFFF_FFFF_FFFF_FFF0, 32'h0);
        put_segment(32'h2, 32'h3, 32'h4, 0);
        put_chunk(64'hFFFF_FFFF_FFFF_FFEC, SigIndx);
        put_entry(rand64(), 64'h10, $urandom());
        put_entry(rand64(), 64'h20, $urandom());
        put_random(10);
        flush_stream();
        begin_response();
        put_segment(32'h9, 32'h9, 32'h9, 0);
        put_chunk(64'h8000_0000_0000_0000, SigIndx);
        put_entry(rand64(), rand64(), $urandom());
        put_random(17);
        flush_stream();

        // Random traffic in three idle profiles.
        limit = bytes_sent + 1550;
        while (bytes_sent < limit) begin
            if (bytes_sent > limit - 1550 * 2 / 3 && send_idle == 13) begin
                send_idle = 46;
                recv_idle = 13;
            end else if (bytes_sent > limit - 1550 / 3 && send_idle == 46) begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_response();
        end
        i_valid <= 0;

        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes in %0d responses; %0d index entries checked.",
                 bytes_sent, responses, sb.matched);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> frame_index_deframer_unit.f
hdl/fidf_pkg.sv
hdl/fidf_front.sv
hdl/fidf_queue.sv
hdl/frame_index_deframer_unit.sv
tb/sv/testbench.sv
